>>> hdl/alu8f_pkg.sv
// Package for the 8-bit serial ALU: operation codes and the control struct
// passed from the sequencer to the datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package alu8f_pkg;

	localparam int unsigned DataW = 8;
	localparam int unsigned CntW  = $clog2(DataW);
	localparam int unsigned SeedW = 16;

	localparam logic [3:0] CMD_ADD  = 4'd0;
	localparam logic [3:0] CMD_SUB  = 4'd1;
	localparam logic [3:0] CMD_DIV  = 4'd2;
	localparam logic [3:0] CMD_MOD  = 4'd3;
	localparam logic [3:0] CMD_MUL  = 4'd4;
	localparam logic [3:0] CMD_INC  = 4'd5;
	localparam logic [3:0] CMD_DEC  = 4'd6;
	localparam logic [3:0] CMD_AND  = 4'd7;
	localparam logic [3:0] CMD_OR   = 4'd8;
	localparam logic [3:0] CMD_XOR  = 4'd9;
	localparam logic [3:0] CMD_NOT  = 4'd10;
	localparam logic [3:0] CMD_SHL  = 4'd11;
	localparam logic [3:0] CMD_SHR  = 4'd12;
	localparam logic [3:0] CMD_RAND = 4'd13;

	localparam logic [DataW-1:0] BYTE_ONE = 8'h01;
	localparam logic [SeedW-1:0] SEED_ONE = 16'h0001;

	typedef struct packed {
		logic load;   // capture a new beat
		logic step;   // one bit step
		logic fin;    // form result and flags
	} ctrl_t;

endpackage
`default_nettype wire

>>> hdl/alu8f_lfsr.sv
// 16-bit Fibonacci LFSR (taps 16,14,13,11) for the rand operation.
// Loaded from the seed write port; depends on alu8f_pkg.
`timescale 1ns / 1ps
`default_nettype none
module alu8f_lfsr (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        seed_we,
	input  wire logic [alu8f_pkg::SeedW-1:0] seed,
	input  wire logic                        advance,
	output logic      [alu8f_pkg::DataW-1:0] rand_byte
);
	import alu8f_pkg::*;

	logic [SeedW-1:0] state_q;
	logic [SeedW-1:0] state_nxt;
	logic             fb;

	assign fb        = state_q[0] ^ state_q[2] ^ state_q[3] ^ state_q[5];
	assign state_nxt = {fb, state_q[SeedW-1:1]};
	assign rand_byte = state_nxt[DataW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEED_ONE;
		end else if (seed_we) begin
			state_q <= (seed == '0) ? SEED_ONE : seed;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

>>> hdl/alu8f_seq.sv
// Sequencer: accepts a beat, runs eight bit steps, then a finish state.
// Depends on alu8f_pkg.
`timescale 1ns / 1ps
`default_nettype none
module alu8f_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	output alu8f_pkg::ctrl_t     ctrl
);
	import alu8f_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t          state_q;
	logic [CntW-1:0] cnt_q;

	assign busy      = (state_q != ST_IDLE);
	assign ctrl.load = start && !busy;
	assign ctrl.step = (state_q == ST_RUN);
	assign ctrl.fin  = (state_q == ST_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(DataW - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/alu8f_dp.sv
// Bit-serial datapath: serial adder, shift-add multiply, restoring divide,
// per-bit logic, and the output registers. Depends on alu8f_pkg.
`timescale 1ns / 1ps
`default_nettype none
module alu8f_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire alu8f_pkg::ctrl_t            ctrl,
	input  wire logic [3:0]                  cmd,
	input  wire logic [alu8f_pkg::DataW-1:0] operand_a,
	input  wire logic [alu8f_pkg::DataW-1:0] operand_b,
	input  wire logic [alu8f_pkg::DataW-1:0] rand_byte,
	output logic                             result_valid,
	output logic      [alu8f_pkg::DataW-1:0] result_byte,
	output logic                             zero_flag,
	output logic                             carry_flag,
	output logic                             sign_flag,
	output logic                             overflow_flag
);
	import alu8f_pkg::*;

	logic [3:0]       cmd_q;
	logic [DataW-1:0] a_q;
	logic [DataW-1:0] b_q;
	logic [DataW-1:0] res_q;
	logic [DataW-1:0] acc_q;
	logic             cy_q;
	logic             c7_q;

	logic             bb;
	logic             sbit;
	logic             cout;
	logic [DataW:0]   msum;
	logic [DataW:0]   rem;
	logic             qbit;
	logic             lbit;
	logic [DataW-1:0] fres;
	logic             fcy;
	logic             fov;

	// serial add, sub through inverted b
	assign bb   = b_q[0] ^ ((cmd_q == CMD_SUB) || (cmd_q == CMD_DEC));
	assign sbit = a_q[0] ^ bb ^ cy_q;
	assign cout = (a_q[0] & bb) | (a_q[0] & cy_q) | (bb & cy_q);

	// multiply: add b into high byte, shift product right
	assign msum = {1'b0, acc_q} + (a_q[0] ? {1'b0, b_q} : '0);

	// restoring divide step
	assign rem  = {acc_q, a_q[DataW-1]};
	assign qbit = (rem >= {1'b0, b_q});

	always_comb begin
		unique case (cmd_q)
			CMD_AND:  lbit = a_q[0] & b_q[0];
			CMD_OR:   lbit = a_q[0] | b_q[0];
			CMD_XOR:  lbit = a_q[0] ^ b_q[0];
			CMD_NOT:  lbit = ~a_q[0];
			CMD_SHR:  lbit = a_q[1];
			CMD_RAND: lbit = a_q[0];
			default:  lbit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= cmd;
			acc_q <= '0;
			res_q <= '0;
			c7_q  <= 1'b0;
			a_q   <= (cmd == CMD_RAND) ? rand_byte : operand_a;
			unique case (cmd)
				CMD_INC, CMD_DEC: b_q <= BYTE_ONE;
				CMD_SHL:          b_q <= operand_a;
				default:          b_q <= operand_b;
			endcase
			unique case (cmd)
				CMD_SUB, CMD_DEC: cy_q <= 1'b1;
				CMD_SHR:          cy_q <= operand_a[0];
				default:          cy_q <= 1'b0;
			endcase
		end else if (ctrl.step) begin
			unique case (cmd_q)
				CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC, CMD_SHL: begin
					a_q   <= a_q >> 1;
					b_q   <= b_q >> 1;
					res_q <= {sbit, res_q[DataW-1:1]};
					cy_q  <= cout;
					c7_q  <= cy_q;
				end
				CMD_MUL: begin
					a_q   <= a_q >> 1;
					acc_q <= msum[DataW:1];
					res_q <= {msum[0], res_q[DataW-1:1]};
				end
				CMD_DIV, CMD_MOD: begin
					a_q   <= a_q << 1;
					acc_q <= qbit ? DataW'(rem - {1'b0, b_q}) : rem[DataW-1:0];
					res_q <= {res_q[DataW-2:0], qbit};
				end
				default: begin
					a_q   <= a_q >> 1;
					b_q   <= b_q >> 1;
					res_q <= {lbit, res_q[DataW-1:1]};
				end
			endcase
		end
	end

	always_comb begin
		fres = res_q;
		fcy  = 1'b0;
		fov  = 1'b0;
		unique case (cmd_q)
			CMD_ADD: begin
				fcy = cy_q;
				fov = cy_q ^ c7_q;
			end
			CMD_SUB: begin
				fcy = ~cy_q;
				fov = cy_q ^ c7_q;
			end
			CMD_INC, CMD_SHL, CMD_SHR: fcy = cy_q;
			CMD_DEC:                   fcy = ~cy_q;
			CMD_MUL:                   fcy = |acc_q;
			CMD_DIV:                   fres = (b_q == '0) ? '0 : res_q;
			CMD_MOD:                   fres = (b_q == '0) ? '0 : acc_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.fin) begin
			result_byte   <= fres;
			zero_flag     <= (fres == '0);
			carry_flag    <= fcy;
			sign_flag     <= fres[DataW-1];
			overflow_flag <= fov;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= ctrl.fin;
		end
	end

endmodule
`default_nettype wire

>>> hdl/alu_8bit_with_flags.sv
// 8-bit ALU with flags, bit-serial: one bit per cycle through shift registers.
// Steps: the accept edge, eight bit steps and a finish state, then a
// one-cycle result_valid strobe. A new beat is taken only when idle, after
// the last beat's finish state. The receiver cannot stall. Async reset
// clears the sequencer and strobe and loads the random generator with seed 1.
`timescale 1ns / 1ps
`default_nettype none
module alu_8bit_with_flags (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [3:0]                  cmd,
	input  wire logic [alu8f_pkg::DataW-1:0] operand_a,
	input  wire logic [alu8f_pkg::DataW-1:0] operand_b,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [alu8f_pkg::SeedW-1:0] cfg_data,
	output logic                             result_valid,
	output logic      [alu8f_pkg::DataW-1:0] result_byte,
	output logic                             zero_flag,
	output logic                             carry_flag,
	output logic                             sign_flag,
	output logic                             overflow_flag
);
	import alu8f_pkg::*;

	ctrl_t            ctrl;
	logic [DataW-1:0] rand_byte;

	assign cfg_ready = 1'b1;

	alu8f_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	alu8f_lfsr u_lfsr (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_we   (cfg_valid && cfg_ready),
		.seed      (cfg_data),
		.advance   (ctrl.load && (cmd == CMD_RAND)),
		.rand_byte (rand_byte)
	);

	alu8f_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.cmd           (cmd),
		.operand_a     (operand_a),
		.operand_b     (operand_b),
		.rand_byte     (rand_byte),
		.result_valid  (result_valid),
		.result_byte   (result_byte),
		.zero_flag     (zero_flag),
		.carry_flag    (carry_flag),
		.sign_flag     (sign_flag),
		.overflow_flag (overflow_flag)
	);

endmodule
`default_nettype wire

>>> test/tb_alu_8bit_with_flags.sv
// Self-checking testbench for alu_8bit_with_flags: directed and random operations
// against an in-bench predictor of result byte, flags and the LFSR state.
// Depends on alu8f_pkg and the alu_8bit_with_flags RTL.
`timescale 1ns / 1ps
module tb_alu_8bit_with_flags;
	import alu8f_pkg::*;

	localparam int unsigned CycleLimit  = 200000;
	localparam int unsigned DrainCycles = 12;
	localparam logic [3:0]  CMD_SPARE_LO = 4'd14;
	localparam logic [3:0]  CMD_SPARE_HI = 4'd15;

	typedef struct packed {
		logic [DataW-1:0] res;
		logic             zero;
		logic             carry;
		logic             sign;
		logic             ovf;
	} alu_flags_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic [3:0]       cmd       = CMD_ADD;
	logic [DataW-1:0] operand_a = '0;
	logic [DataW-1:0] operand_b = '0;
	logic             cfg_valid = 1'b0;
	logic [SeedW-1:0] cfg_data  = '0;
	logic             busy;
	logic             cfg_ready;
	logic             result_valid;
	logic [DataW-1:0] result_byte;
	logic             zero_flag;
	logic             carry_flag;
	logic             sign_flag;
	logic             overflow_flag;

	alu_flags_t       expected_results[$];
	logic [SeedW-1:0] lfsr_state;
	int unsigned      error_count = 0;
	int unsigned      cycle_count = 0;
	int unsigned      idle_pct    = 0;

	alu_8bit_with_flags i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_byte  (result_byte),
		.zero_flag    (zero_flag),
		.carry_flag   (carry_flag),
		.sign_flag    (sign_flag),
		.overflow_flag(overflow_flag)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("%0t: timeout", $time);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Advances the generator on rand, so call exactly once per accepted beat.
	function automatic alu_flags_t alu_predict(input logic [3:0] op,
			input logic [DataW-1:0] a, input logic [DataW-1:0] b);
		alu_flags_t       r;
		logic [DataW:0]   wide;
		logic [15:0]      prod;
		logic             fb;
		r = '0;
		case (op)
			CMD_ADD: begin
				wide    = {1'b0, a} + {1'b0, b};
				r.res   = wide[DataW-1:0];
				r.carry = wide[DataW];
				r.ovf   = (a[7] == b[7]) && (r.res[7] != a[7]);
			end
			CMD_SUB: begin
				r.res   = a - b;
				r.carry = a < b;
				r.ovf   = (a[7] != b[7]) && (r.res[7] != a[7]);
			end
			CMD_DIV: r.res = (b != '0) ? a / b : '0;
			CMD_MOD: r.res = (b != '0) ? a % b : '0;
			CMD_MUL: begin
				prod    = {8'd0, a} * {8'd0, b};
				r.res   = prod[7:0];
				r.carry = |prod[15:8];
			end
			CMD_INC: begin
				r.res   = a + BYTE_ONE;
				r.carry = &a;
			end
			CMD_DEC: begin
				r.res   = a - BYTE_ONE;
				r.carry = a == '0;
			end
			CMD_AND: r.res = a & b;
			CMD_OR:  r.res = a | b;
			CMD_XOR: r.res = a ^ b;
			CMD_NOT: r.res = ~a;
			CMD_SHL: begin
				r.carry = a[7];
				r.res   = {a[6:0], 1'b0};
			end
			CMD_SHR: begin
				r.carry = a[0];
				r.res   = {1'b0, a[7:1]};
			end
			CMD_RAND: begin
				fb         = lfsr_state[0] ^ lfsr_state[2] ^ lfsr_state[3] ^ lfsr_state[5];
				lfsr_state = {fb, lfsr_state[15:1]};
				r.res      = lfsr_state[7:0];
			end
			default: r.res = '0;
		endcase
		r.zero = r.res == '0;
		r.sign = r.res[7];
		return r;
	endfunction

	task automatic check_field(input string what, input logic [DataW-1:0] want,
			input logic [DataW-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		alu_flags_t want;
		alu_flags_t got;
		if (arst_n && result_valid) begin
			got = {result_byte, zero_flag, carry_flag, sign_flag, overflow_flag};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, got);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("result_byte", want.res, got.res);
				check_field("zero_flag", DataW'(want.zero), DataW'(got.zero));
				check_field("carry_flag", DataW'(want.carry), DataW'(got.carry));
				check_field("sign_flag", DataW'(want.sign), DataW'(got.sign));
				check_field("overflow_flag", DataW'(want.ovf), DataW'(got.ovf));
			end
		end
	end

	// Called at a falling edge; returns at a falling edge.
	task automatic send_op(input logic [3:0] op, input logic [DataW-1:0] a,
			input logic [DataW-1:0] b);
		start     <= 1'b1;
		cmd       <= op;
		operand_a <= a;
		operand_b <= b;
		do @(posedge clk); while (busy);
		expected_results.push_back(alu_predict(op, a, b));
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(negedge clk);
		while (expected_results.size() != 0 || busy)
			@(negedge clk);
	endtask

	task automatic write_seed(input logic [SeedW-1:0] seed);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= seed;
		do @(posedge clk); while (!cfg_ready);
		lfsr_state = (seed == '0) ? SEED_ONE : seed;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [DataW-1:0] rand_byte();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h7F;
			default: return DataW'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [3:0] rand_cmd();
		if ($urandom_range(99) < 3)
			return 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		return 4'($urandom_range(CMD_ADD, CMD_RAND));
	endfunction

	task automatic test_add_sub_flags();
		send_op(CMD_ADD, 8'hFF, 8'h01);
		send_op(CMD_ADD, 8'h7F, 8'h01);
		send_op(CMD_ADD, 8'h80, 8'h80);
		send_op(CMD_ADD, 8'h00, 8'h00);
		send_op(CMD_SUB, 8'h00, 8'h01);
		send_op(CMD_SUB, 8'h80, 8'h01);
		send_op(CMD_SUB, 8'h55, 8'h55);
	endtask

	task automatic test_mul_div_inc_dec();
		send_op(CMD_DIV, 8'hFF, 8'h00);
		send_op(CMD_MOD, 8'h07, 8'h00);
		send_op(CMD_DIV, 8'hFF, 8'h01);
		send_op(CMD_MOD, 8'hFF, 8'h10);
		send_op(CMD_MUL, 8'hFF, 8'hFF);
		send_op(CMD_MUL, 8'h0F, 8'h11);
		send_op(CMD_INC, 8'hFF, 8'h00);
		send_op(CMD_DEC, 8'h00, 8'hFF);
		send_op(CMD_DEC, 8'h80, 8'h00);
	endtask

	task automatic test_logic_shift();
		send_op(CMD_AND, 8'hFF, 8'hAA);
		send_op(CMD_OR, 8'h00, 8'h00);
		send_op(CMD_XOR, 8'h55, 8'hAA);
		send_op(CMD_NOT, 8'hFF, 8'h00);
		send_op(CMD_SHL, 8'h80, 8'h00);
		send_op(CMD_SHR, 8'h01, 8'h00);
		send_op(CMD_SHR, 8'hFE, 8'h00);
		// unused codes give zero result
		send_op(CMD_SPARE_LO, 8'hFF, 8'hFF);
		send_op(CMD_SPARE_HI, 8'hAA, 8'h55);
	endtask

	task automatic test_random_seed();
		repeat (3) send_op(CMD_RAND, 8'h00, 8'h00);
		// zero seed must fall back to one
		write_seed(16'h0000);
		repeat (2) send_op(CMD_RAND, 8'hFF, 8'hFF);
		write_seed(16'hFFFF);
		repeat (3) send_op(CMD_RAND, 8'h00, 8'h00);
		write_seed(16'h8000);
		repeat (2) send_op(CMD_RAND, 8'h00, 8'h00);
		write_seed(SEED_ONE);
		send_op(CMD_RAND, 8'h00, 8'h00);
	endtask

	task automatic test_random_mix(input int unsigned n_ops, input int unsigned pct);
		idle_pct = pct;
		write_seed(SeedW'($urandom_range(1, 16'hFFFF)));
		repeat (n_ops) send_op(rand_cmd(), rand_byte(), rand_byte());
	endtask

	task automatic test_drain_pause();
		idle_pct = 0;
		repeat (20) begin
			repeat (3) send_op(rand_cmd(), rand_byte(), rand_byte());
			wait_drained();
		end
	endtask

	initial begin
		lfsr_state = SEED_ONE;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_add_sub_flags();
		test_mul_div_inc_dec();
		test_logic_shift();
		test_random_seed();
		test_random_mix(360, 6);
		test_random_mix(360, 75);
		test_drain_pause();
		test_random_mix(360, 0);
		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
